### sv/wcag_contrast_ratio_core_defines.svh
// ----------------------------------------------------------------------------
// WCAG contrast ratio core - assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WCAG_CONTRAST_RATIO_CORE_DEFINES_SVH
`define WCAG_CONTRAST_RATIO_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset
`define WCR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wcr: assertion failed");

// Checked on every clock edge, reset included
`define WCR_ASSERT_IN_RESET(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wcr: assertion failed during or after reset");

`else

`define WCR_ASSERT(lbl, clk, rstn, prop)
`define WCR_ASSERT_IN_RESET(lbl, clk, prop)

`endif

`endif

### sv/wcr_pkg.sv
// ----------------------------------------------------------------------------
// WCAG contrast ratio package
// Widths, fixed-point constants, payload types and the sRGB linearization
// table shared by the contrast ratio core.
// ----------------------------------------------------------------------------
package wcr_pkg;

  // Field widths
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned LIN_W     = 17;   // Q0.16, up to 1.0
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned PROD_W    = LIN_W + WEIGHT_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned LUM_W     = 16;
  localparam int unsigned OFF_W     = 17;   // luminance plus 0.05
  localparam int unsigned FRAC_W    = 8;    // ratio fraction bits
  localparam int unsigned NUM_W     = OFF_W + FRAC_W;
  localparam int unsigned RATIO_W   = 13;
  localparam int unsigned LIN_ENTRIES = 1 << CODE_W;

  // Default number of quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS_DEF = 4;

  // Luminance weights in Q0.16, index 0 red, 1 green, 2 blue
  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46872;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;
  localparam logic [2:0][WEIGHT_W-1:0] LUMA_WEIGHT = {W_BLUE, W_GREEN, W_RED};

  localparam logic [SUM_W-1:0]   LUM_ROUND  = SUM_W'(32768);
  localparam logic [OFF_W-1:0]   LUM_OFFSET = 17'd3277;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = 13'd256;
  localparam logic [RATIO_W-1:0] RATIO_MAX  = 13'd5375;

  // Constants of the transfer function in fixed point
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] LIN_SEG_DEN = 64'd658920;   // 2 * 255 * 12.92 * 100
  localparam logic [63:0] POW_DEN     = 64'd269025;   // 255 * 1055

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [LIN_ENTRIES-1:0][LIN_W-1:0] lin_table_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
  } pix_pair_t;

  typedef struct packed {
    logic [LUM_W-1:0] first;
    logic [LUM_W-1:0] second;
  } lum_pair_t;

  // x^5 in Q0.30, each product truncated
  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] p;
    p = (r * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    return p;
  endfunction

  // Linear value of one sRGB code, Q0.16; evaluated at elaboration only
  function automatic lin_t lin_entry(input int unsigned code);
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] x;
    logic [63:0] p;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] v;
    c = 64'(code);
    if (c * 64'd100000 <= 64'd1001640) begin
      return lin_t'((c * 64'd13107200 + 64'd329460) / LIN_SEG_DEN);
    end
    n = 64'd1000 * c + 64'd14025;
    x = (n << 30) / POW_DEN;
    p = (x * x) >> 30;
    // fifth root of x^2 by bisection, then x^2 * x^0.4 = x^2.4
    lo = '0;
    hi = ONE_Q30;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= p) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    v = (p * lo) >> 30;
    return lin_t'((v + 64'd8192) >> 14);
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t t;
    for (int unsigned i = 0; i < LIN_ENTRIES; i++) begin
      t[i] = lin_entry(i);
    end
    return t;
  endfunction

  // sRGB code to linear light, Q0.16
  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

### sv/wcr_in_if.sv
// ----------------------------------------------------------------------------
// WCAG contrast ratio input channel
// Valid/ready channel carrying one pair of 8-bit sRGB colors.
// ----------------------------------------------------------------------------
interface wcr_in_if;
  import wcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] first_red;
  logic [CODE_W-1:0] first_green;
  logic [CODE_W-1:0] first_blue;
  logic [CODE_W-1:0] second_red;
  logic [CODE_W-1:0] second_green;
  logic [CODE_W-1:0] second_blue;

  modport source (
    output valid, first_red, first_green, first_blue,
    output second_red, second_green, second_blue,
    input  ready
  );

  modport sink (
    input  valid, first_red, first_green, first_blue,
    input  second_red, second_green, second_blue,
    output ready
  );

endinterface

### sv/wcr_out_if.sv
// ----------------------------------------------------------------------------
// WCAG contrast ratio result channel
// Valid/ready channel carrying the ratio and both luminances.
// ----------------------------------------------------------------------------
interface wcr_out_if;
  import wcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] ratio_q8;
  logic [LUM_W-1:0]   first_luminance;
  logic [LUM_W-1:0]   second_luminance;

  modport source (
    output valid, ratio_q8, first_luminance, second_luminance,
    input  ready
  );

  modport sink (
    input  valid, ratio_q8, first_luminance, second_luminance,
    output ready
  );

endinterface

### sv/wcag_contrast_ratio_core.sv
// ----------------------------------------------------------------------------
// WCAG 2 contrast ratio core
// Relative luminance of two sRGB colors and their contrast ratio in Q.8.
// ----------------------------------------------------------------------------
// Takes one color pair per clock unless stalled, and returns, in order, one
// result per pair: the contrast ratio (lighter + 0.05) / (darker + 0.05) in
// unsigned Q.8, truncated, and both relative luminances in Q0.16 (white
// saturates at 65535). The stages are table lookup, weighting multiplies,
// luminance sum, ordering and offset, then the pipelined restoring divider,
// DIV_STEPS quotient bits per stage (1 to 12). The result register drains
// independently, so a stall on the result side holds the pipeline without
// dropping items and a free slot anywhere lets a new pair in. There is no
// configuration and no state.
`include "wcag_contrast_ratio_core_defines.svh"

module wcag_contrast_ratio_core #(
  parameter int unsigned DIV_STEPS = wcr_pkg::DIV_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wcr_in_if.sink           in_i,
  wcr_out_if.source        out_o
);
  import wcr_pkg::*;

  localparam int unsigned DivStages = (RATIO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned QuoW      = DivStages * DIV_STEPS;

  pix_pair_t        pix;
  lum_pair_t        luma_lum;
  logic             luma_valid;
  logic             ord_rdy;

  logic [LUM_W-1:0] lighter;
  logic [LUM_W-1:0] darker;
  logic [OFF_W-1:0] lighter_off;
  logic [NUM_W-1:0] num;
  logic             ord_valid_q;
  logic [OFF_W-1:0] ord_rem_q;
  logic [OFF_W-1:0] ord_den_q;
  logic [QuoW-1:0]  ord_dq_q;
  lum_pair_t        ord_lum_q;

  logic             vld_w [DivStages+1];
  logic             rdy_w [DivStages+1];
  logic [OFF_W-1:0] rem_w [DivStages+1];
  logic [OFF_W-1:0] den_w [DivStages+1];
  logic [QuoW-1:0]  dq_w  [DivStages+1];
  lum_pair_t        lum_w [DivStages+1];

  // Input item into the luminance pipeline
  always_comb begin
    pix.first.red    = in_i.first_red;
    pix.first.green  = in_i.first_green;
    pix.first.blue   = in_i.first_blue;
    pix.second.red   = in_i.second_red;
    pix.second.green = in_i.second_green;
    pix.second.blue  = in_i.second_blue;
  end

  wcr_luma u_luma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .pix_i       (pix),
    .out_valid_o (luma_valid),
    .out_ready_i (ord_rdy),
    .lum_o       (luma_lum)
  );

  // Ordering stage: pick lighter/darker, add 0.05, set up the division
  always_comb begin
    if (luma_lum.first > luma_lum.second) begin
      lighter = luma_lum.first;
      darker  = luma_lum.second;
    end else begin
      lighter = luma_lum.second;
      darker  = luma_lum.first;
    end
    lighter_off = OFF_W'(lighter) + LUM_OFFSET;
    num         = {lighter_off, {FRAC_W{1'b0}}};
  end

  assign ord_rdy = !ord_valid_q || rdy_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_valid_q <= 1'b0;
    end else if (ord_rdy) begin
      ord_valid_q <= luma_valid;
    end
  end

  // Quotient is below 2^13, so the high dividend bits start below the divisor
  always_ff @(posedge clk_i) begin
    if (luma_valid && ord_rdy) begin
      ord_rem_q <= OFF_W'(num >> QuoW);
      ord_den_q <= OFF_W'(darker) + LUM_OFFSET;
      ord_dq_q  <= num[QuoW-1:0];
      ord_lum_q <= luma_lum;
    end
  end

  // Divider pipeline
  assign vld_w[0] = ord_valid_q;
  assign rem_w[0] = ord_rem_q;
  assign den_w[0] = ord_den_q;
  assign dq_w[0]  = ord_dq_q;
  assign lum_w[0] = ord_lum_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    wcr_div_stage #(
      .STEPS (DIV_STEPS),
      .QUO_W (QuoW)
    ) u_div_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld_w[g]),
      .in_ready_o  (rdy_w[g]),
      .in_rem_i    (rem_w[g]),
      .in_den_i    (den_w[g]),
      .in_dq_i     (dq_w[g]),
      .in_lum_i    (lum_w[g]),
      .out_valid_o (vld_w[g+1]),
      .out_ready_i (rdy_w[g+1]),
      .out_rem_o   (rem_w[g+1]),
      .out_den_o   (den_w[g+1]),
      .out_dq_o    (dq_w[g+1]),
      .out_lum_o   (lum_w[g+1])
    );
  end

  // Result item
  assign rdy_w[DivStages]       = out_o.ready;
  assign out_o.valid            = vld_w[DivStages];
  assign out_o.ratio_q8         = dq_w[DivStages][RATIO_W-1:0];
  assign out_o.first_luminance  = lum_w[DivStages].first;
  assign out_o.second_luminance = lum_w[DivStages].second;

  // Checks; valid may still be unknown before the first reset edge
  `WCR_ASSERT_IN_RESET(a_no_result_in_reset, clk_i, !rst_ni |-> (out_o.valid !== 1'b1))
  `WCR_ASSERT(a_ready_chain, clk_i, rst_ni, out_o.ready |-> in_i.ready)
  `WCR_ASSERT(a_ratio_range, clk_i, rst_ni, out_o.valid |-> ((out_o.ratio_q8 >= RATIO_ONE) && (out_o.ratio_q8 <= RATIO_MAX)))
  `WCR_ASSERT(a_equal_is_one, clk_i, rst_ni, (out_o.valid && (out_o.first_luminance == out_o.second_luminance)) |-> (out_o.ratio_q8 == RATIO_ONE))
  `WCR_ASSERT(a_rem_below_den, clk_i, rst_ni, out_o.valid |-> (rem_w[DivStages] < den_w[DivStages]))

endmodule

### sv/wcr_luma.sv
// ----------------------------------------------------------------------------
// WCAG contrast ratio - luminance pipeline
// Three stages: table linearization, weighting multiplies, rounded sum with
// saturation. Computes both colors of a pair side by side.
// ----------------------------------------------------------------------------
module wcr_luma (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wcr_pkg::pix_pair_t pix_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wcr_pkg::lum_pair_t lum_o
);
  import wcr_pkg::*;

  localparam int unsigned NStages = 3;

  logic [NStages-1:0] valid_q;
  logic [NStages-1:0] valid_d;
  logic [NStages-1:0] rdy;
  logic [NStages-1:0] en;

  logic [CODE_W-1:0] code [2][3];
  logic [LIN_W-1:0]  lin_q [2][3];
  logic [PROD_W-1:0] prod_d [2][3];
  logic [PROD_W-1:0] prod_q [2][3];
  logic [SUM_W-1:0]  sum [2];
  logic [LUM_W-1:0]  lum_sat [2];
  lum_pair_t         lum_d;
  lum_pair_t         lum_q;

  // Stage handshake: a stage takes new data when empty or draining
  always_comb begin
    rdy[2] = !valid_q[2] || out_ready_i;
    rdy[1] = !valid_q[1] || rdy[2];
    rdy[0] = !valid_q[0] || rdy[1];
    en[0]  = in_valid_i && rdy[0];
    en[1]  = valid_q[0] && rdy[1];
    en[2]  = valid_q[1] && rdy[2];
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = rdy[2] ? valid_q[1] : valid_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: linearize all six channels through the table
  always_comb begin
    code[0][0] = pix_i.first.red;
    code[0][1] = pix_i.first.green;
    code[0][2] = pix_i.first.blue;
    code[1][0] = pix_i.second.red;
    code[1][1] = pix_i.second.green;
    code[1][2] = pix_i.second.blue;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int p = 0; p < 2; p++) begin
        for (int c = 0; c < 3; c++) begin
          lin_q[p][c] <= LIN_TABLE[code[p][c]];
        end
      end
    end
  end

  // Stage 2: apply the channel weights
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[p][c] = PROD_W'(lin_q[p][c]) * PROD_W'(LUMA_WEIGHT[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: sum, round to Q0.16, saturate (white overshoots 1.0)
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sum[p] = SUM_W'(prod_q[p][0]) + SUM_W'(prod_q[p][1])
             + SUM_W'(prod_q[p][2]) + LUM_ROUND;
      if (|sum[p][SUM_W-1:LUM_W+16]) begin
        lum_sat[p] = '1;
      end else begin
        lum_sat[p] = sum[p][LUM_W+15:16];
      end
    end
    lum_d.first  = lum_sat[0];
    lum_d.second = lum_sat[1];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lum_q <= lum_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[2];
  assign lum_o       = lum_q;

endmodule

### sv/wcr_div_stage.sv
// ----------------------------------------------------------------------------
// WCAG contrast ratio - divider stage
// One register stage of a restoring divider: resolves STEPS quotient bits.
// Dividend bits shift out of the top of dq while quotient bits shift in.
// ----------------------------------------------------------------------------
module wcr_div_stage #(
  parameter int unsigned STEPS = wcr_pkg::DIV_STEPS_DEF,
  parameter int unsigned QUO_W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wcr_pkg::OFF_W-1:0]  in_rem_i,
  input  logic [wcr_pkg::OFF_W-1:0]  in_den_i,
  input  logic [QUO_W-1:0]           in_dq_i,
  input  wcr_pkg::lum_pair_t         in_lum_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wcr_pkg::OFF_W-1:0]  out_rem_o,
  output logic [wcr_pkg::OFF_W-1:0]  out_den_o,
  output logic [QUO_W-1:0]           out_dq_o,
  output wcr_pkg::lum_pair_t         out_lum_o
);
  import wcr_pkg::*;

  logic             valid_q;
  logic             rdy;
  logic             en;
  logic [OFF_W:0]   rem_sh;
  logic [OFF_W-1:0] rem_d;
  logic [QUO_W-1:0] dq_d;
  logic [OFF_W-1:0] rem_q;
  logic [OFF_W-1:0] den_q;
  logic [QUO_W-1:0] dq_q;
  lum_pair_t        lum_q;

  assign rdy = !valid_q || out_ready_i;
  assign en  = in_valid_i && rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  // Shift-compare-subtract, STEPS times
  always_comb begin
    rem_d  = in_rem_i;
    dq_d   = in_dq_i;
    rem_sh = '0;
    for (int unsigned s = 0; s < STEPS; s++) begin
      rem_sh = {rem_d, dq_d[QUO_W-1]};
      if (rem_sh >= {1'b0, in_den_i}) begin
        rem_d = OFF_W'(rem_sh - {1'b0, in_den_i});
        dq_d  = {dq_d[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = OFF_W'(rem_sh);
        dq_d  = {dq_d[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q <= rem_d;
      den_q <= in_den_i;
      dq_q  <= dq_d;
      lum_q <= in_lum_i;
    end
  end

  assign in_ready_o  = rdy;
  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_den_o   = den_q;
  assign out_dq_o    = dq_q;
  assign out_lum_o   = lum_q;

endmodule
